// ===== design/waypoint_follower_p_control_core_defines.svh =====
// ----------------------------------------------------------------------------
// waypoint follower assertion macros
// shared property forms for the port checker, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOWER_P_CONTROL_CORE_DEFINES_SVH
`define WAYPOINT_FOLLOWER_P_CONTROL_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define WPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpf_pkg
// types and constants shared by the waypoint follower controller, datapath
// and checker
// ----------------------------------------------------------------------------
package wpf_pkg;

  // fixed field widths, table limit and gain shift
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned TABLE_LIMIT = 16;
  localparam int unsigned GAIN_SHIFT  = 12;

  // configuration reset values
  localparam logic signed [15:0] GAIN_RESET  = 16'sd4096;
  localparam logic [4:0]         COUNT_RESET = 5'd1;

  // drive saturation limits
  localparam logic signed [15:0] DRIVE_MAX = 16'sh7fff;
  localparam logic signed [15:0] DRIVE_MIN = 16'sh8000;

  // request operation codes
  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_REWIND = 2'd2
  } wpf_op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAIN_GAIN  = 2'd0,
    CFG_CROSS_GAIN = 2'd1,
    CFG_WP_COUNT   = 2'd2
  } wpf_cfg_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_SQ,
    ST_RAD,
    ST_CMP,
    ST_REERR,
    ST_GAIN,
    ST_OUT
  } wpf_state_e;

  // operand selection for the shared multiplier pair
  typedef enum logic [1:0] {
    MUL_SQUARE,
    MUL_RADIUS,
    MUL_GAIN
  } wpf_mul_e;

  // one waypoint table entry
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] radius;
    logic        axis;
  } wpf_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic     start;
    logic     load;
    logic     rewind;
    logic     err_en;
    logic     mul_en;
    wpf_mul_e mul_sel;
    logic     d2_en;
    logic     cmp_en;
    logic     out_load;
  } wpf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic advance;
    logic out_free;
  } wpf_status_t;

endpackage

// ===== design/wpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpf_ctrl
// sequencer for the waypoint follower: takes requests, runs the capture
// check and the gain pass of a step through the datapath
// ----------------------------------------------------------------------------
module wpf_ctrl import wpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  wpf_status_t status_i,
  output wpf_cmd_t    cmd_o
);

  wpf_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_STEP)) state_d = ST_ERR;
      end
      ST_ERR:   state_d = ST_SQ;
      ST_SQ:    state_d = ST_RAD;
      ST_RAD:   state_d = ST_CMP;
      ST_CMP:   state_d = status_i.advance ? ST_REERR : ST_GAIN;
      ST_REERR: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_SQUARE;
    in_stall_o     = (state_q != ST_IDLE);
    cmd_o.start    = accept && (operation_i == OP_STEP);
    cmd_o.load     = accept && (operation_i == OP_LOAD);
    cmd_o.rewind   = accept && (operation_i == OP_REWIND);
    unique case (state_q)
      ST_ERR, ST_REERR: cmd_o.err_en = 1'b1;
      ST_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQUARE;
      end
      ST_RAD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RADIUS;
        cmd_o.d2_en   = 1'b1;
      end
      ST_CMP:  cmd_o.cmp_en = 1'b1;
      ST_GAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN;
      end
      ST_OUT:  cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/wpf_dp.sv =====
// ----------------------------------------------------------------------------
// wpf_dp
// waypoint follower datapath: waypoint table, configuration registers,
// error and square terms on a shared multiplier pair, saturation and the
// result register
// ----------------------------------------------------------------------------
module wpf_dp import wpf_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [15:0] position_x_i,
  input  logic signed [15:0] position_y_i,
  input  logic [3:0]         waypoint_slot_i,
  input  logic signed [15:0] waypoint_x_i,
  input  logic signed [15:0] waypoint_y_i,
  input  logic [14:0]        waypoint_radius_i,
  input  logic               waypoint_axis_i,
  input  wpf_cmd_t           cmd_i,
  output wpf_status_t        status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_x_o,
  output logic signed [15:0] drive_y_o,
  output logic [3:0]         target_index_o,
  output logic               at_final_o,
  output logic               saturated_o
);

  localparam int unsigned DEPTH  = (MAX_WAYPOINTS < TABLE_LIMIT) ? MAX_WAYPOINTS : TABLE_LIMIT;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0]  DEPTH5 = 5'(DEPTH);

  // configuration and control state
  logic signed [15:0] main_gain_q, cross_gain_q;
  logic [4:0]         count_q;
  logic [IDX_W-1:0]   cur_q;
  logic               out_valid_q;

  // working registers
  wpf_entry_t         wp_mem_q [DEPTH];
  wpf_entry_t         rd_q;
  logic signed [15:0] px_q, py_q;
  logic [IDX_W-1:0]   idx_q;
  logic signed [16:0] ex_q, ey_q;
  logic signed [33:0] prod_x_q, prod_y_q;
  logic [34:0]        d2_q;

  logic [4:0]         n_used;
  logic [IDX_W-1:0]   last_idx, clamp_idx, idx_inc;
  logic               advance;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               slot_ok;
  wpf_entry_t         wr_entry;
  logic signed [16:0] a_x, b_x, a_y, b_y;
  logic signed [33:0] mul_x, mul_y;
  logic signed [33:0] sh_x, sh_y;
  logic               ovf_x, ovf_y;
  logic signed [15:0] drv_x, drv_y;

  // last index in use, count clipped to the table depth
  always_comb begin
    if (count_q == 5'd0) begin
      n_used = 5'd1;
    end else if (count_q > DEPTH5) begin
      n_used = DEPTH5;
    end else begin
      n_used = count_q;
    end
    last_idx = IDX_W'(n_used - 5'd1);
  end

  assign clamp_idx = (cur_q > last_idx) ? last_idx : cur_q;
  assign idx_inc   = idx_q + IDX_W'(1);
  assign advance   = (d2_q < {1'b0, prod_x_q}) && (idx_q < last_idx);

  assign status_o.advance  = advance;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // configuration registers and current target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_gain_q  <= GAIN_RESET;
      cross_gain_q <= GAIN_RESET;
      count_q      <= COUNT_RESET;
      cur_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAIN_GAIN:  main_gain_q  <= cfg_data_i;
          CFG_CROSS_GAIN: cross_gain_q <= cfg_data_i;
          CFG_WP_COUNT:   count_q      <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.rewind) begin
        cur_q <= '0;
      end else if (cmd_i.cmp_en) begin
        cur_q <= advance ? idx_inc : idx_q;
      end
    end
  end

  // waypoint table, one write and one registered read port
  assign slot_ok  = (int'(waypoint_slot_i) < DEPTH);
  assign wr_entry = '{x: waypoint_x_i, y: waypoint_y_i,
                      radius: waypoint_radius_i, axis: waypoint_axis_i};
  assign rd_en    = cmd_i.start || (cmd_i.cmp_en && advance);
  assign rd_addr  = cmd_i.start ? clamp_idx[AW-1:0] : idx_inc[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      wp_mem_q[waypoint_slot_i[AW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= wp_mem_q[rd_addr];
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SQUARE: begin
        a_x = ex_q;
        b_x = ex_q;
        a_y = ey_q;
        b_y = ey_q;
      end
      MUL_RADIUS: begin
        a_x = $signed({2'b00, rd_q.radius});
        b_x = $signed({2'b00, rd_q.radius});
        a_y = '0;
        b_y = '0;
      end
      MUL_GAIN: begin
        a_x = 17'(rd_q.axis ? cross_gain_q : main_gain_q);
        b_x = ex_q;
        a_y = 17'(rd_q.axis ? main_gain_q : cross_gain_q);
        b_y = ey_q;
      end
      default: begin
        a_x = '0;
        b_x = '0;
        a_y = '0;
        b_y = '0;
      end
    endcase
  end

  assign mul_x = a_x * b_x;
  assign mul_y = a_y * b_y;

  // step working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q  <= position_x_i;
      py_q  <= position_y_i;
      idx_q <= clamp_idx;
    end else if (cmd_i.cmp_en && advance) begin
      idx_q <= idx_inc;
    end
    if (cmd_i.err_en) begin
      ex_q <= 17'($signed(rd_q.x)) - 17'(px_q);
      ey_q <= 17'($signed(rd_q.y)) - 17'(py_q);
    end
    if (cmd_i.d2_en) begin
      d2_q <= {1'b0, prod_x_q} + {1'b0, prod_y_q};
    end
    if (cmd_i.mul_en) begin
      prod_x_q <= mul_x;
      prod_y_q <= mul_y;
    end
  end

  // back to q8.8 with floor shift, then clip to 16 bits
  assign sh_x  = prod_x_q >>> GAIN_SHIFT;
  assign sh_y  = prod_y_q >>> GAIN_SHIFT;
  assign ovf_x = !((sh_x[33:15] == '0) || (sh_x[33:15] == '1));
  assign ovf_y = !((sh_y[33:15] == '0) || (sh_y[33:15] == '1));
  assign drv_x = ovf_x ? (sh_x[33] ? DRIVE_MIN : DRIVE_MAX) : sh_x[15:0];
  assign drv_y = ovf_y ? (sh_y[33] ? DRIVE_MIN : DRIVE_MAX) : sh_y[15:0];

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      drive_x_o      <= drv_x;
      drive_y_o      <= drv_y;
      target_index_o <= idx_q;
      at_final_o     <= (idx_q == last_idx);
      saturated_o    <= ovf_x || ovf_y;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/waypoint_follower_p_control_core.sv =====
// ----------------------------------------------------------------------------
// waypoint_follower_p_control_core
// 2-d waypoint follower with proportional drive in fixed point
// ----------------------------------------------------------------------------
// A step request runs the error, square, radius, compare, gain and output
// states, with a second error state after compare when the position lies
// inside the current waypoint's radius and the index moves on; the result
// is registered in the output state, which waits on a stalled result. This
// is set by one pair of 17x17 multipliers used in turn for the squared errors,
// the squared radius and the two gain products, and by the single registered
// read port of the waypoint table, which is read again after an advance. Load,
// rewind and unused requests leave the block idle and give no result. A
// finished result waits in an output register while the next request is taken.
// Table entries hold garbage until loaded; no clearing pass follows reset.
module waypoint_follower_p_control_core import wpf_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] position_x_i,
  input  logic signed [15:0] position_y_i,
  input  logic [3:0]         waypoint_slot_i,
  input  logic signed [15:0] waypoint_x_i,
  input  logic signed [15:0] waypoint_y_i,
  input  logic [14:0]        waypoint_radius_i,
  input  logic               waypoint_axis_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_x_o,
  output logic signed [15:0] drive_y_o,
  output logic [3:0]         target_index_o,
  output logic               at_final_o,
  output logic               saturated_o
);

  wpf_cmd_t    cmd;
  wpf_status_t status;

  // sequencer
  wpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  wpf_dp #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .position_x_i      (position_x_i),
    .position_y_i      (position_y_i),
    .waypoint_slot_i   (waypoint_slot_i),
    .waypoint_x_i      (waypoint_x_i),
    .waypoint_y_i      (waypoint_y_i),
    .waypoint_radius_i (waypoint_radius_i),
    .waypoint_axis_i   (waypoint_axis_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .drive_x_o         (drive_x_o),
    .drive_y_o         (drive_y_o),
    .target_index_o    (target_index_o),
    .at_final_o        (at_final_o),
    .saturated_o       (saturated_o)
  );

endmodule

// ===== design/wpf_checker.sv =====
// ----------------------------------------------------------------------------
// wpf_checker
// port level checks for the waypoint follower, bound to the top level
// ----------------------------------------------------------------------------
`include "waypoint_follower_p_control_core_defines.svh"

module wpf_checker import wpf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] drive_x_o,
  input logic [15:0] drive_y_o,
  input logic [3:0]  target_index_o
);

  // a held result stays valid
  `WPF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // a held result keeps its payload
  `WPF_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(drive_x_o) && $stable(drive_y_o) && $stable(target_index_o), "result changed while stalled")

  // a taken step request keeps the block busy
  `WPF_ASSERT_NEXT(a_step_busy, in_valid_i && !in_stall_o && (operation_i == OP_STEP), in_stall_o, "step request did not start work")

  // load and rewind finish in the cycle they are taken
  `WPF_ASSERT_NEXT(a_quick_ops, in_valid_i && !in_stall_o && ((operation_i == OP_LOAD) || (operation_i == OP_REWIND)), !in_stall_o, "load or rewind held the request side")

  // a new result only comes out of step work
  `WPF_ASSERT_SAME(a_result_source, $rose(out_valid_o), $past(in_stall_o), "result appeared without step work")

endmodule

bind waypoint_follower_p_control_core wpf_checker u_wpf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .operation_i    (operation_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .drive_x_o      (drive_x_o),
  .drive_y_o      (drive_y_o),
  .target_index_o (target_index_o)
);

// ===== tb/sv/tb_waypoint_follower_p_control_core.sv =====
// ----------------------------------------------------------------------------
// tb_waypoint_follower_p_control_core
// self-checking bench for the waypoint follower: a directed run over corner
// positions, capture boundaries and register extremes, then random phases of
// loads, steps and rewinds under changing gains and waypoint counts; each
// drive result is checked against a tracked copy of table, index and gains
// ----------------------------------------------------------------------------
module tb_waypoint_follower_p_control_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wpf_pkg::*;

  // request code with no operation behind it
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_ITEMS   = 230;
  localparam int         SETTLE_CYCLES = 12;

  // one request as driven on the input side
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [3:0]  slot;
    logic [15:0] wp_x;
    logic [15:0] wp_y;
    logic [14:0] radius;
    logic        axis;
  } wp_request_t;

  // one drive result as seen on the output side
  typedef struct packed {
    logic [15:0] drive_x;
    logic [15:0] drive_y;
    logic [3:0]  target;
    logic        at_final;
    logic        saturated;
  } drive_result_t;

  // tracks table, index and gains, predicts drives and checks them in order
  class drive_tracker;
    wpf_entry_t    wp_mem [TABLE_LIMIT];
    bit            wp_loaded [TABLE_LIMIT];
    logic [15:0]   main_gain;
    logic [15:0]   cross_gain;
    logic [4:0]    wp_count;
    logic [3:0]    target;
    drive_result_t pending_drives [$];
    int            errors;

    function new();
      foreach (wp_loaded[i]) wp_loaded[i] = 1'b0;
      main_gain  = GAIN_RESET;
      cross_gain = GAIN_RESET;
      wp_count   = COUNT_RESET;
      target     = '0;
      errors     = 0;
    endfunction

    function void write_reg(wpf_cfg_e idx, logic [15:0] data);
      case (idx)
        CFG_MAIN_GAIN:  main_gain = data;
        CFG_CROSS_GAIN: cross_gain = data;
        CFG_WP_COUNT:   wp_count = data[4:0];
        default: ;
      endcase
    endfunction

    // last waypoint in use: count 0 acts as 1, large counts clip to the table
    function int last_slot();
      if (wp_count == 0) return 0;
      if (wp_count > TABLE_LIMIT) return TABLE_LIMIT - 1;
      return int'(wp_count) - 1;
    endfunction

    // index a step starts from, pulled back when the count was lowered
    function int start_slot();
      return (int'(target) > last_slot()) ? last_slot() : int'(target);
    endfunction

    // q4.12 gain times q8.8 error, floor back to q8.8, clip to 16 bits
    function logic [15:0] scale_error(logic [15:0] gain, int err, inout bit clipped);
      longint prod;
      prod = (longint'($signed(gain)) * longint'(err)) >>> GAIN_SHIFT;
      if (prod > 32767) begin
        clipped = 1'b1;
        return DRIVE_MAX;
      end
      if (prod < -32768) begin
        clipped = 1'b1;
        return DRIVE_MIN;
      end
      return prod[15:0];
    endfunction

    function void note_request(wp_request_t r);
      int            idx;
      int            last;
      int            ex;
      int            ey;
      longint        d2;
      longint        r2;
      bit            clipped;
      wpf_entry_t    w;
      drive_result_t res;
      case (r.op)
        OP_LOAD: begin
          wp_mem[r.slot]    = {r.wp_x, r.wp_y, r.radius, r.axis};
          wp_loaded[r.slot] = 1'b1;
        end
        OP_REWIND: target = '0;
        OP_STEP: begin
          last = last_slot();
          idx  = start_slot();
          // capture test on squared distance, strictly inside the radius
          w  = wp_mem[idx];
          ex = int'($signed(w.x)) - int'($signed(r.pos_x));
          ey = int'($signed(w.y)) - int'($signed(r.pos_y));
          d2 = longint'(ex) * ex + longint'(ey) * ey;
          r2 = longint'(w.radius) * longint'(w.radius);
          if (d2 < r2 && idx < last) idx++;
          target = 4'(idx);
          // drive against the waypoint now selected
          w  = wp_mem[idx];
          ex = int'($signed(w.x)) - int'($signed(r.pos_x));
          ey = int'($signed(w.y)) - int'($signed(r.pos_y));
          clipped = 1'b0;
          if (w.axis) begin
            res.drive_x = scale_error(cross_gain, ex, clipped);
            res.drive_y = scale_error(main_gain, ey, clipped);
          end else begin
            res.drive_x = scale_error(main_gain, ex, clipped);
            res.drive_y = scale_error(cross_gain, ey, clipped);
          end
          res.target    = 4'(idx);
          res.at_final  = (idx == last);
          res.saturated = clipped;
          pending_drives.insert(pending_drives.size(), res);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_drive(drive_result_t got);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: drive result with none pending: expected none actual %h",
                 $time, got);
        return;
      end
      want = pending_drives.pop_front();
      compare_field("drive_x", want.drive_x, got.drive_x);
      compare_field("drive_y", want.drive_y, got.drive_y);
      compare_field("target_index", 16'(want.target), 16'(got.target));
      compare_field("at_final", 16'(want.at_final), 16'(got.at_final));
      compare_field("saturated", 16'(want.saturated), 16'(got.saturated));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [15:0] position_x = '0;
  logic [15:0] position_y = '0;
  logic [3:0]  waypoint_slot = '0;
  logic [15:0] waypoint_x = '0;
  logic [15:0] waypoint_y = '0;
  logic [14:0] waypoint_radius = '0;
  logic        waypoint_axis = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] drive_x;
  logic [15:0] drive_y;
  logic [3:0]  target_index;
  logic        at_final;
  logic        saturated;

  drive_tracker tracker;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int           rx_hold = 0;

  waypoint_follower_p_control_core u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .position_x_i      (position_x),
    .position_y_i      (position_y),
    .waypoint_slot_i   (waypoint_slot),
    .waypoint_x_i      (waypoint_x),
    .waypoint_y_i      (waypoint_y),
    .waypoint_radius_i (waypoint_radius),
    .waypoint_axis_i   (waypoint_axis),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .drive_x_o         (drive_x),
    .drive_y_o         (drive_y),
    .target_index_o    (target_index),
    .at_final_o        (at_final),
    .saturated_o       (saturated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side stalls at random, in bursts
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_hold   <= int'($urandom_range(0, 3));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_drive({drive_x, drive_y, target_index, at_final, saturated});
  end

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // request with every field random, op included
  function automatic wp_request_t noise_request();
    logic [95:0] raw;
    wp_request_t r;
    raw = {$urandom, $urandom, $urandom};
    r   = raw[$bits(wp_request_t)-1:0];
    return r;
  endfunction

  function automatic wp_request_t make_load(int slot, logic [15:0] x, logic [15:0] y,
                                            logic [14:0] radius, logic axis);
    wp_request_t r;
    r        = noise_request();
    r.op     = OP_LOAD;
    r.slot   = 4'(slot);
    r.wp_x   = x;
    r.wp_y   = y;
    r.radius = radius;
    r.axis   = axis;
    return r;
  endfunction

  // waypoint with mostly nearby centres and moderate radii
  function automatic wp_request_t rand_load(int slot);
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] radius;
    if ($urandom_range(0, 3) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else begin
      x = clip16(int'($urandom_range(0, 8192)) - 4096);
      y = clip16(int'($urandom_range(0, 8192)) - 4096);
    end
    case ($urandom_range(0, 9))
      0:       radius = '0;
      1:       radius = '1;
      2:       radius = 15'($urandom);
      default: radius = 15'($urandom_range(16, 1536));
    endcase
    return make_load(slot, x, y, radius, 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 16'h4000)) - 16'h2000);
    endcase
  endfunction

  // count with random upper bits, which the register drops
  function automatic logic [15:0] pick_count();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       v[4:0] = 5'd0;
      1:       v[4:0] = 5'd1;
      2:       v[4:0] = 5'd31;
      3:       v[4:0] = 5'd16;
      4:       v[4:0] = 5'($urandom_range(17, 31));
      default: v[4:0] = 5'($urandom_range(2, 16));
    endcase
    return v;
  endfunction

  // hand one request over, then maybe idle for a short burst
  task automatic send_request(wp_request_t r);
    in_valid        <= 1'b1;
    operation       <= r.op;
    position_x      <= r.pos_x;
    position_y      <= r.pos_y;
    waypoint_slot   <= r.slot;
    waypoint_x      <= r.wp_x;
    waypoint_y      <= r.wp_y;
    waypoint_radius <= r.radius;
    waypoint_axis   <= r.axis;
    do @(posedge clk); while (in_stall);
    tracker.note_request(r);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_plain(logic [1:0] op);
    wp_request_t r;
    r    = noise_request();
    r.op = op;
    send_request(r);
  endtask

  // load any waypoint the next step may read that was never written
  task automatic prepare_targets();
    int idx;
    idx = tracker.start_slot();
    for (int s = idx; s <= idx + 1 && s <= tracker.last_slot(); s++)
      if (!tracker.wp_loaded[s]) send_request(rand_load(s));
  endtask

  task automatic send_step(logic [15:0] px, logic [15:0] py);
    wp_request_t r;
    prepare_targets();
    r       = noise_request();
    r.op    = OP_STEP;
    r.pos_x = px;
    r.pos_y = py;
    send_request(r);
  endtask

  // stop sending and let every pending drive come out
  task automatic quiesce();
    in_valid <= 1'b0;
    while (tracker.pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(wpf_cfg_e idx, logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // step mostly around the current waypoint so that captures happen
  task automatic random_step();
    wpf_entry_t  w;
    int          reach;
    logic [15:0] px;
    logic [15:0] py;
    prepare_targets();
    w     = tracker.wp_mem[tracker.start_slot()];
    reach = int'(w.radius) * 7 / 10;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        px = clip16(int'($signed(w.x)) + int'($urandom_range(0, 2 * reach)) - reach);
        py = clip16(int'($signed(w.y)) + int'($urandom_range(0, 2 * reach)) - reach);
      end
      4: begin
        px = clip16(int'($signed(w.x)) + int'(w.radius));
        py = w.y;
      end
      5: begin
        px = corner_value();
        py = corner_value();
      end
      default: begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
    endcase
    send_step(px, py);
  endtask

  task automatic random_phase(int n_items, bit hold_midway);
    int sent;
    int roll;
    int slot;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                           : tracker.start_slot() + $urandom_range(0, 2);
        send_request(rand_load(slot > 15 ? 15 : slot));
        sent++;
      end else if (roll < 15) begin
        send_plain(OP_REWIND);
        sent++;
      end else if (roll < 17) begin
        send_plain(OP_UNUSED);
      end else begin
        random_step();
        sent++;
      end
      // sender holds off at the midpoint until the block has drained
      if (hold_midway && sent == n_items / 2) quiesce();
    end
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: single waypoint, unit gains
    send_request(make_load(0, 16'h7fff, 16'h8000, 15'h7fff, 1'b0));
    send_step(16'h8000, 16'h7fff);
    send_step(16'h7fff, 16'h8000);
    send_plain(OP_UNUSED);
    send_plain(OP_REWIND);
    send_request(make_load(0, 16'h0000, 16'h0000, 15'h0000, 1'b1));
    send_step(16'h0000, 16'h0000);
    quiesce();

    // extreme gains, four waypoints, exact radius boundary
    write_reg(CFG_MAIN_GAIN, 16'h7fff);
    write_reg(CFG_CROSS_GAIN, 16'h8000);
    write_reg(CFG_WP_COUNT, 16'h0004);
    send_request(make_load(1, 16'h0000, 16'h0000, 15'd3, 1'b1));
    send_request(make_load(2, 16'h0064, 16'hff9c, 15'h7fff, 1'b0));
    send_request(make_load(3, 16'hff00, 16'h0100, 15'h0100, 1'b1));
    send_request(make_load(0, 16'h0200, 16'h0200, 15'h0100, 1'b0));
    send_step(16'h0200, 16'h0200);
    send_step(16'h0003, 16'h0000);
    send_step(16'h0002, 16'h0002);
    send_step(16'h0000, 16'h0000);
    send_step(16'hff00, 16'h0100);
    quiesce();

    // count lowered below the index, then zero, then above the table size
    write_reg(CFG_WP_COUNT, 16'hffe2);
    send_step(16'hffff, 16'hffff);
    quiesce();
    write_reg(CFG_WP_COUNT, 16'h0000);
    send_step(16'h0001, 16'h0001);
    quiesce();
    write_reg(CFG_WP_COUNT, 16'h001f);
    write_reg(CFG_MAIN_GAIN, 16'h0000);
    write_reg(CFG_CROSS_GAIN, 16'hffff);
    send_step(16'h0200, 16'h0200);
    send_plain(OP_REWIND);
    send_step(16'h8000, 16'h8000);
    quiesce();

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_MAIN_GAIN, pick_gain());
      write_reg(CFG_CROSS_GAIN, pick_gain());
      write_reg(CFG_WP_COUNT, pick_count());
      tx_idle_en = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      random_phase(PHASE_ITEMS, p == 1);
      quiesce();
    end

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
